// ----- sv/mttp_pkg.sv -----
`default_nettype none
package mttp_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int CFG_W       = 31;
	localparam int CFG_IDX_W   = 1;
	localparam int TIME_W      = 61;
	localparam int SUM_W       = 62;
	localparam int WIDE_W      = 64;
	localparam int DIV_W       = WIDE_W + FRAC_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
	localparam int ROOT_W      = 32;
	localparam int ROOT_CNT_W  = $clog2(ROOT_W + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = CFG_W'(65536);
	localparam logic [CFG_W-1:0] ACCEL_LIMIT_RST = CFG_W'(65536);

	localparam logic [SUM_W-1:0]  BEST_INIT = SUM_W'(64'd999999 << FRAC_BITS);
	localparam logic [TIME_W-1:0] TIME_CAP  = {1'b1, {(TIME_W-1){1'b0}}};
	localparam logic [CFG_W-1:0]  TIME_SAT  = {CFG_W{1'b1}};

	localparam logic signed [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] POS_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] x0;
		logic signed [DATA_W-1:0] v0;
		logic signed [DATA_W-1:0] v1;
		logic signed [DATA_W:0]   dx;
	} item_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     num;
		logic [WIDE_W-1:0]    den;
		logic [DIV_CNT_W-1:0] count;
	} div_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ0,
		ST_SQ1,
		ST_PROD,
		ST_VV,
		ST_AV,
		ST_DISC,
		ST_ROOT,
		ST_CAND,
		ST_DIV1,
		ST_DIV3,
		ST_DIV2,
		ST_PICK,
		ST_VCSQ,
		ST_ADV1,
		ST_ADV2,
		ST_ADV3,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

// ----- sv/mttp_front.sv -----
`default_nettype none
module mttp_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [mttp_pkg::DATA_W-1:0]  start_pos,
	input  logic signed [mttp_pkg::DATA_W-1:0]  start_vel,
	input  logic signed [mttp_pkg::DATA_W-1:0]  goal_pos,
	input  logic signed [mttp_pkg::DATA_W-1:0]  goal_vel,
	output logic                                item_valid,
	output mttp_pkg::item_t                     item,
	input  logic                                item_pop
);
	import mttp_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	item_t             new_item;

	assign in_ready   = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign item_valid = (cnt_q != '0);
	assign item       = mem_q[rd_ptr_q];

	always_comb begin
		new_item.x0 = start_pos;
		new_item.v0 = start_vel;
		new_item.v1 = goal_vel;
		new_item.dx = (DATA_W+1)'(goal_pos) - (DATA_W+1)'(start_pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (item_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !item_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && item_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

endmodule
`default_nettype wire

// ----- sv/mttp_div.sv -----
`default_nettype none
module mttp_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mttp_pkg::div_req_t              req,
	output logic                            done,
	output logic [mttp_pkg::DIV_W-1:0]      quo
);
	import mttp_pkg::*;

	logic [DIV_W-1:0]     n_q;
	logic [WIDE_W-1:0]    den_q;
	logic [WIDE_W-1:0]    rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [WIDE_W:0]      rem_sh;
	logic [WIDE_W:0]      rem_nx;
	logic                 ge;

	always_comb begin
		rem_sh = {rem_q, n_q[DIV_W-1]};
		ge     = (rem_sh >= {1'b0, den_q});
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.count;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[DIV_W-2:0], 1'b0};
			rem_q <= rem_nx[WIDE_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

// ----- sv/mttp_sqrt.sv -----
`default_nettype none
module mttp_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [mttp_pkg::WIDE_W-1:0]       radicand,
	output logic                              done,
	output logic [mttp_pkg::ROOT_W-1:0]       root
);
	import mttp_pkg::*;

	localparam int REM_W = ROOT_W + 3;

	logic [WIDE_W-1:0]     x_q;
	logic [REM_W-1:0]      rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [ROOT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [REM_W+1:0]      rem_sh;
	logic [REM_W+1:0]      trial;
	logic [REM_W+1:0]      rem_nx;
	logic                  ge;

	always_comb begin
		rem_sh = {rem_q, x_q[WIDE_W-1:WIDE_W-2]};
		trial  = {3'b000, root_q, 2'b01};
		ge     = (rem_sh >= trial);
		rem_nx = ge ? rem_sh - trial : rem_sh;
	end

	assign done = done_q;
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ROOT_CNT_W'(ROOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ROOT_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[WIDE_W-3:0], 2'b00};
			rem_q  <= rem_nx[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

// ----- sv/mttp_back.sv -----
`default_nettype none
module mttp_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  mttp_pkg::item_t                     item,
	output logic                                item_pop,
	input  logic [mttp_pkg::CFG_W-1:0]          speed_limit,
	input  logic [mttp_pkg::CFG_W-1:0]          accel_limit,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                found,
	output logic signed [mttp_pkg::DATA_W-1:0]  accel,
	output logic [mttp_pkg::CFG_W-1:0]          t_accel,
	output logic [mttp_pkg::CFG_W-1:0]          t_cruise,
	output logic [mttp_pkg::CFG_W-1:0]          t_decel,
	output logic signed [mttp_pkg::DATA_W-1:0]  cruise_vel,
	output logic signed [mttp_pkg::DATA_W-1:0]  pos_after_accel,
	output logic signed [mttp_pkg::DATA_W-1:0]  pos_after_cruise,
	output logic signed [mttp_pkg::DATA_W-1:0]  end_pos,
	output logic signed [mttp_pkg::DATA_W-1:0]  end_vel
);
	import mttp_pkg::*;

	localparam int M_W = DATA_W + 1;

	function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
		return x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
	endfunction

	function automatic logic [CFG_W-1:0] sat_time(input logic [TIME_W-1:0] t);
		return (t >= TIME_W'(TIME_SAT)) ? TIME_SAT : t[CFG_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] adv_pos(
		input logic signed [DATA_W-1:0] base,
		input logic                     neg,
		input logic [WIDE_W-1:0]        q
	);
		logic signed [DATA_W+2:0] qs;
		logic signed [DATA_W+2:0] sum;
		qs  = signed'({2'b00, q[DATA_W:0]});
		sum = neg ? (DATA_W+3)'(base) - qs : (DATA_W+3)'(base) + qs;
		if (|q[WIDE_W-1:DATA_W+1]) begin
			return neg ? POS_MIN : POS_MAX;
		end else if (sum > (DATA_W+3)'(POS_MAX)) begin
			return POS_MAX;
		end else if (sum < (DATA_W+3)'(POS_MIN)) begin
			return POS_MIN;
		end
		return sum[DATA_W-1:0];
	endfunction

	state_t state_q, state_d;
	logic   si_q, si_d;
	logic   k_q, k_d;
	logic   mode_q, mode_d;
	logic   run_q, run_d;
	logic   out_valid_q;

	logic signed [DATA_W-1:0] x0_q, v0_q, v1_q;
	logic signed [DATA_W:0]   dx_q;
	logic [WIDE_W-1:0]        sq0_q, sq1_q, half_q, prod_q, d_q, bd_q, vcsq_q;
	logic [SUM_W-1:0]         vv_q, av_q, best_q;
	logic [ROOT_W-1:0]        r_q;
	logic signed [DATA_W-1:0] cand_q, bvc_q, p1_q, p2_q, p3_q;
	logic [M_W-1:0]           m1_q, m3_q;
	logic [TIME_W-1:0]        t1_q, t2_q, t3_q, bt1_q, bt2_q, bt3_q;
	logic                     bs_q, found_q, coast_q;

	logic                     found_o_q;
	logic signed [DATA_W-1:0] accel_o_q, vc_o_q, p1_o_q, p2_o_q, p3_o_q, ve_o_q;
	logic [CFG_W-1:0]         t1_o_q, t2_o_q, t3_o_q;

	logic [DATA_W-1:0]        v0_mag, v1_mag, dx_mag, bvc_mag, vsel;
	logic                     disc_neg, disc_ok, coast_ok, cand_ok, ok1, ok3, take;
	logic                     found_any, r_gt, out_free, vneg;
	logic [WIDE_W-1:0]        disc_val, mag1, mag3;
	logic signed [DATA_W-1:0] vel;
	logic signed [M_W:0]      diff1, diff3;
	logic [M_W-1:0]           m1, m3;
	logic [SUM_W-1:0]         t_sum;
	logic [TIME_W-1:0]        t2_val;
	logic                     neg1, neg3, adv_neg;
	logic signed [DATA_W-1:0] adv_base, adv_res;
	state_t                   eos_state, eoc_state;
	logic                     eos_si, eos_mode, eoc_k;

	div_req_t          div_req;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic              sqrt_start;
	logic              sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;

	mttp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	mttp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (d_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// candidate arithmetic
	always_comb begin
		v0_mag   = mag32(v0_q);
		v1_mag   = mag32(v1_q);
		dx_mag   = dx_q[DATA_W] ? DATA_W'(-dx_q) : DATA_W'(dx_q);
		bvc_mag  = mag32(bvc_q);
		disc_neg = dx_q[DATA_W] ^ ~si_q;
		disc_ok  = !disc_neg || (prod_q <= half_q);
		disc_val = disc_neg ? half_q - prod_q : half_q + prod_q;
		vsel     = mode_q ? {1'b0, speed_limit} : r_q;
		vneg     = mode_q ? !si_q : k_q;
		vel      = vneg ? -signed'(vsel) : signed'(vsel);
		diff1    = (M_W+1)'(vel) - (M_W+1)'(v0_q);
		diff3    = (M_W+1)'(vel) - (M_W+1)'(v1_q);
		ok1      = si_q ? !diff1[M_W] : (diff1[M_W] || diff1 == '0);
		ok3      = si_q ? !diff3[M_W] : (diff3[M_W] || diff3 == '0);
		m1       = diff1[M_W] ? M_W'(-diff1) : M_W'(diff1);
		m3       = diff3[M_W] ? M_W'(-diff3) : M_W'(diff3);
		cand_ok  = ok1 && ok3;
		coast_ok = ok1 && ok3 && disc_ok && (disc_val >= WIDE_W'(vv_q));
		t_sum    = SUM_W'(t1_q) + SUM_W'(t3_q) + (mode_q ? SUM_W'(t2_q) : '0);
		take     = (t_sum < best_q);
		found_any = found_q || (state_q == ST_PICK && take);
		r_gt     = (sqrt_root > {1'b0, speed_limit});
		t2_val   = (|div_quo[DIV_W-1:TIME_W-1]) ? TIME_CAP : div_quo[TIME_W-1:0];
		out_free = !out_valid_q || out_ready;
		neg1     = (vcsq_q < sq0_q) ^ ~bs_q;
		neg3     = (vcsq_q < sq1_q) ^ ~bs_q;
		mag1     = (vcsq_q < sq0_q) ? sq0_q - vcsq_q : vcsq_q - sq0_q;
		mag3     = (vcsq_q < sq1_q) ? sq1_q - vcsq_q : vcsq_q - sq1_q;
	end

	always_comb begin
		adv_base = x0_q;
		adv_neg  = neg1;
		unique case (state_q)
			ST_ADV2: begin
				adv_base = p1_q;
				adv_neg  = ~bs_q;
			end
			ST_ADV3: begin
				adv_base = p2_q;
				adv_neg  = neg3;
			end
			default: begin
				adv_base = x0_q;
				adv_neg  = neg1;
			end
		endcase
		adv_res = adv_pos(adv_base, adv_neg, div_quo[WIDE_W-1:0]);
	end

	// end of a sign and end of a candidate
	always_comb begin
		eos_si   = si_q;
		eos_mode = mode_q;
		if (!si_q) begin
			eos_state = ST_DISC;
			eos_si    = 1'b1;
		end else if (!mode_q && !found_any && speed_limit != '0) begin
			eos_state = ST_DISC;
			eos_si    = 1'b0;
			eos_mode  = 1'b1;
		end else begin
			eos_state = found_any ? ST_VCSQ : ST_OUT;
		end
		eoc_k = k_q;
		if (!mode_q && !k_q) begin
			eoc_state = ST_CAND;
			eoc_k     = 1'b1;
		end else begin
			eoc_state = eos_state;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		si_d    = si_q;
		k_d     = k_q;
		mode_d  = mode_q;
		run_d   = run_q;
		unique case (state_q)
			ST_IDLE: if (item_valid) begin
				state_d = ST_SQ0;
				si_d    = 1'b0;
				k_d     = 1'b0;
				mode_d  = 1'b0;
			end
			ST_SQ0:  state_d = ST_SQ1;
			ST_SQ1:  state_d = ST_PROD;
			ST_PROD: state_d = ST_VV;
			ST_VV:   state_d = ST_AV;
			ST_AV:   state_d = (accel_limit == '0) ? ST_OUT : ST_DISC;
			ST_DISC: begin
				if (mode_q ? coast_ok : disc_ok) begin
					state_d = mode_q ? ST_DIV1 : ST_ROOT;
				end else begin
					state_d = eos_state;
					si_d    = eos_si;
					mode_d  = eos_mode;
				end
			end
			ST_ROOT: begin
				if (!run_q) begin
					run_d = 1'b1;
				end else if (sqrt_done) begin
					run_d = 1'b0;
					if (r_gt) begin
						state_d = eos_state;
						si_d    = eos_si;
						mode_d  = eos_mode;
					end else begin
						state_d = ST_CAND;
						k_d     = 1'b0;
					end
				end
			end
			ST_CAND: begin
				if (cand_ok) begin
					state_d = ST_DIV1;
				end else begin
					state_d = eoc_state;
					k_d     = eoc_k;
					if (k_q) begin
						si_d   = eos_si;
						mode_d = eos_mode;
					end
				end
			end
			ST_DIV1, ST_DIV3, ST_DIV2, ST_ADV1, ST_ADV2, ST_ADV3: begin
				if (!run_q) begin
					run_d = 1'b1;
				end else if (div_done) begin
					run_d = 1'b0;
					unique case (state_q)
						ST_DIV1: state_d = ST_DIV3;
						ST_DIV3: state_d = mode_q ? ST_DIV2 : ST_PICK;
						ST_DIV2: state_d = ST_PICK;
						ST_ADV1: state_d = coast_q ? ST_ADV2 : ST_ADV3;
						ST_ADV2: state_d = ST_ADV3;
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_PICK: begin
				state_d = eoc_state;
				k_d     = eoc_k;
				if (mode_q || k_q) begin
					si_d   = eos_si;
					mode_d = eos_mode;
				end
			end
			ST_VCSQ: state_d = ST_ADV1;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// unit requests and queue pop
	always_comb begin
		item_pop      = (state_q == ST_IDLE) && item_valid;
		sqrt_start    = (state_q == ST_ROOT) && !run_q;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = WIDE_W'(accel_limit);
		div_req.count = DIV_CNT_W'(M_W + FRAC_BITS);
		unique case (state_q)
			ST_DIV1: begin
				div_req.start = !run_q;
				div_req.num   = {m1_q, {(DIV_W-M_W){1'b0}}};
			end
			ST_DIV3: begin
				div_req.start = !run_q;
				div_req.num   = {m3_q, {(DIV_W-M_W){1'b0}}};
			end
			ST_DIV2: begin
				div_req.start = !run_q;
				div_req.num   = {d_q - WIDE_W'(vv_q), {FRAC_BITS{1'b0}}};
				div_req.den   = WIDE_W'(av_q);
				div_req.count = DIV_CNT_W'(DIV_W);
			end
			ST_ADV1: begin
				div_req.start = !run_q;
				div_req.num   = {mag1, {FRAC_BITS{1'b0}}};
				div_req.den   = WIDE_W'({accel_limit, 1'b0});
				div_req.count = DIV_CNT_W'(WIDE_W);
			end
			ST_ADV2: begin
				div_req.start = !run_q;
				div_req.num   = {bd_q - WIDE_W'(vv_q), {FRAC_BITS{1'b0}}};
				div_req.count = DIV_CNT_W'(WIDE_W);
			end
			ST_ADV3: begin
				div_req.start = !run_q;
				div_req.num   = {mag3, {FRAC_BITS{1'b0}}};
				div_req.den   = WIDE_W'({accel_limit, 1'b0});
				div_req.count = DIV_CNT_W'(WIDE_W);
			end
			default: div_req.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			si_q        <= 1'b0;
			k_q         <= 1'b0;
			mode_q      <= 1'b0;
			run_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			si_q    <= si_d;
			k_q     <= k_d;
			mode_q  <= mode_d;
			run_q   <= run_d;
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (item_valid) begin
				x0_q    <= item.x0;
				v0_q    <= item.v0;
				v1_q    <= item.v1;
				dx_q    <= item.dx;
				found_q <= 1'b0;
				coast_q <= 1'b0;
				bs_q    <= 1'b0;
				best_q  <= BEST_INIT;
			end
			ST_SQ0:  sq0_q <= WIDE_W'(v0_mag) * WIDE_W'(v0_mag);
			ST_SQ1:  sq1_q <= WIDE_W'(v1_mag) * WIDE_W'(v1_mag);
			ST_PROD: begin
				half_q <= WIDE_W'(((WIDE_W+1)'(sq0_q) + (WIDE_W+1)'(sq1_q)) >> 1);
				prod_q <= WIDE_W'(accel_limit) * WIDE_W'(dx_mag);
			end
			ST_VV:   vv_q <= SUM_W'(speed_limit) * SUM_W'(speed_limit);
			ST_AV:   av_q <= SUM_W'(accel_limit) * SUM_W'(speed_limit);
			ST_DISC: begin
				d_q    <= disc_val;
				cand_q <= vel;
				m1_q   <= m1;
				m3_q   <= m3;
			end
			ST_ROOT: if (run_q && sqrt_done) r_q <= sqrt_root;
			ST_CAND: begin
				cand_q <= vel;
				m1_q   <= m1;
				m3_q   <= m3;
			end
			ST_DIV1: if (run_q && div_done) t1_q <= div_quo[TIME_W-1:0];
			ST_DIV3: if (run_q && div_done) t3_q <= div_quo[TIME_W-1:0];
			ST_DIV2: if (run_q && div_done) t2_q <= t2_val;
			ST_PICK: if (take) begin
				best_q  <= t_sum;
				bs_q    <= si_q;
				bt1_q   <= t1_q;
				bt2_q   <= mode_q ? t2_q : '0;
				bt3_q   <= t3_q;
				bvc_q   <= cand_q;
				bd_q    <= d_q;
				found_q <= 1'b1;
				coast_q <= mode_q;
			end
			ST_VCSQ: vcsq_q <= WIDE_W'(bvc_mag) * WIDE_W'(bvc_mag);
			ST_ADV1: if (run_q && div_done) begin
				p1_q <= adv_res;
				p2_q <= adv_res;
			end
			ST_ADV2: if (run_q && div_done) p2_q <= adv_res;
			ST_ADV3: if (run_q && div_done) p3_q <= adv_res;
			ST_OUT: if (out_free) begin
				found_o_q <= found_q;
				accel_o_q <= !found_q ? '0 :
					(bs_q ? signed'({1'b0, accel_limit}) : -signed'({1'b0, accel_limit}));
				t1_o_q    <= found_q ? sat_time(bt1_q) : '0;
				t2_o_q    <= found_q ? sat_time(bt2_q) : '0;
				t3_o_q    <= found_q ? sat_time(bt3_q) : '0;
				vc_o_q    <= found_q ? bvc_q : v0_q;
				p1_o_q    <= found_q ? p1_q : x0_q;
				p2_o_q    <= found_q ? p2_q : x0_q;
				p3_o_q    <= found_q ? p3_q : x0_q;
				ve_o_q    <= found_q ? v1_q : v0_q;
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign found            = found_o_q;
	assign accel            = accel_o_q;
	assign t_accel          = t1_o_q;
	assign t_cruise         = t2_o_q;
	assign t_decel          = t3_o_q;
	assign cruise_vel       = vc_o_q;
	assign pos_after_accel  = p1_o_q;
	assign pos_after_cruise = p2_o_q;
	assign end_pos          = p3_o_q;
	assign end_vel          = ve_o_q;

endmodule
`default_nettype wire

// ----- sv/min_time_trapezoid_planner_core.sv -----
`default_nettype none
// channel  | handshake            | payload
// in       | in_valid / in_ready  | start_pos start_vel goal_pos goal_vel
// out      | out_valid / out_ready| found accel t_accel t_cruise t_decel cruise_vel
//          |                      | pos_after_accel pos_after_cruise end_pos end_vel
// cfg      | cfg_we (no wait)     | cfg_idx cfg_data
//
// a request with a zero acceleration limit skips the search; otherwise its time is set
// by the shared one-bit-per-cycle divider (one division per phase time, one for the coast
// time, one per position) and the two-bit-per-cycle square root (one root per sign).
// a two-entry queue takes new requests while the sequencer works; a finished result
// waits in the output register while the next request starts.
// arst_n clears control state and loads both limits with 1.0.
module min_time_trapezoid_planner_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [mttp_pkg::DATA_W-1:0]  start_pos,
	input  logic signed [mttp_pkg::DATA_W-1:0]  start_vel,
	input  logic signed [mttp_pkg::DATA_W-1:0]  goal_pos,
	input  logic signed [mttp_pkg::DATA_W-1:0]  goal_vel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                found,
	output logic signed [mttp_pkg::DATA_W-1:0]  accel,
	output logic [mttp_pkg::CFG_W-1:0]          t_accel,
	output logic [mttp_pkg::CFG_W-1:0]          t_cruise,
	output logic [mttp_pkg::CFG_W-1:0]          t_decel,
	output logic signed [mttp_pkg::DATA_W-1:0]  cruise_vel,
	output logic signed [mttp_pkg::DATA_W-1:0]  pos_after_accel,
	output logic signed [mttp_pkg::DATA_W-1:0]  pos_after_cruise,
	output logic signed [mttp_pkg::DATA_W-1:0]  end_pos,
	output logic signed [mttp_pkg::DATA_W-1:0]  end_vel,
	input  logic                                cfg_we,
	input  logic [mttp_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [mttp_pkg::CFG_W-1:0]          cfg_data
);
	import mttp_pkg::*;

	logic [CFG_W-1:0] speed_limit_q;
	logic [CFG_W-1:0] accel_limit_q;
	logic             item_valid;
	item_t            item;
	logic             item_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q <= SPEED_LIMIT_RST;
			accel_limit_q <= ACCEL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SPEED_LIMIT: speed_limit_q <= cfg_data;
				REG_ACCEL_LIMIT: accel_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mttp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_pos  (start_pos),
		.start_vel  (start_vel),
		.goal_pos   (goal_pos),
		.goal_vel   (goal_vel),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	mttp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item             (item),
		.item_pop         (item_pop),
		.speed_limit      (speed_limit_q),
		.accel_limit      (accel_limit_q),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.found            (found),
		.accel            (accel),
		.t_accel          (t_accel),
		.t_cruise         (t_cruise),
		.t_decel          (t_decel),
		.cruise_vel       (cruise_vel),
		.pos_after_accel  (pos_after_accel),
		.pos_after_cruise (pos_after_cruise),
		.end_pos          (end_pos),
		.end_vel          (end_vel)
	);

endmodule
`default_nettype wire
